[rtl/core/cbls_pkg.sv]
// Shared constants for the centered boxcar line smoother.
`timescale 1ns / 1ps
package cbls_pkg;

  localparam int unsigned OUT_W     = 16;
  localparam int unsigned WPTS_W    = 5;
  localparam int unsigned RECIP_W   = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned FRAC_BITS = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_POINTS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RECIPROCAL = 2'd1;

  localparam logic [WPTS_W-1:0]  WPTS_RESET  = 5'd1;
  localparam logic [RECIP_W-1:0] RECIP_ONE   = 17'd65536;

endpackage

[rtl/core/cbls_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cbls_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 31,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/centered_boxcar_line_smoother.sv]
// Centered boxcar line smoother: top level.
`timescale 1ns / 1ps
// Usage:
//   Input channel: one beat per line sample (sample, keep mask, last-of-line).
//   Output channel: one beat per line position: window sum times the reciprocal
//   (65536 in pass-through), >> 16, saturated; keep mask of that position;
//   line_done at the line's end; config_error for an even or too big window.
//   Config channel: cfg_ready_o is always high; index 0 = window_points
//   (clears the line state), index 1 = window_reciprocal. Write only when idle.
// Throughput: one sample per cycle in a line unless the output stalls. Without
//   bypass the last sample of a line starts a drain with in_stall_o high; its
//   steps reuse the sample RAM read port to retire the trailing positions.
// Pipeline: a result passes the RAM read, sum/multiply and saturate registers,
//   the last of which is the output register; a position completes when the
//   sample half a window later arrives, or during the drain.
// Reset: window_points 1 (pass-through), reciprocal 65536, empty pipeline.
//   The window RAMs are not cleared; no entry is used before this line wrote it.
// Stall: an output stall freezes the whole pipeline; input is accepted again
//   as soon as the output beat is taken, unless a drain is running.
module centered_boxcar_line_smoother #(
  parameter int unsigned MAX_WINDOW   = 31,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_value_i,
  input  logic                                 keep_mask_i,
  input  logic                                 last_of_line_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [cbls_pkg::OUT_W-1:0]    average_value_o,
  output logic                                 keep_out_o,
  output logic                                 line_done_o,
  output logic                                 config_error_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cbls_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [cbls_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned PW    = $clog2(MAX_WINDOW);
  localparam int unsigned CW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SW    = SAMPLE_WIDTH + CW;
  localparam int unsigned PRODW = SW + cbls_pkg::RECIP_W + 1;
  localparam logic signed [PRODW-1:0] SAT_HI = PRODW'(32767);
  localparam logic signed [PRODW-1:0] SAT_LO = PRODW'(-32768);

  typedef struct packed {
    logic                    valid;
    logic                    bypass;
    logic                    emit;
    logic                    sub;
    logic                    done;
    logic                    clear;
    logic                    keep;
    logic                    err;
    logic [SAMPLE_WIDTH-1:0] x;
  } s1_ctl_t;

  // configuration
  logic [cbls_pkg::WPTS_W-1:0]  wpts_q;
  logic [cbls_pkg::RECIP_W-1:0] recip_q;
  logic                         cfg_we;
  logic                         wpts_we;

  // issue stage
  logic [PW-1:0] wp_q, wp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          drain_q, drain_d;
  logic [CW-1:0] dj_q, dj_d;
  logic [PW-1:0] dwp_q, dwp_d;
  logic [CW-1:0] dcnt_q, dcnt_d;

  logic [CW-1:0] win, half, cnt_new;
  logic [PW:0]   wine, hale, wpe, dwpe, dje;
  logic [PW:0]   nxt_raw, nxt_mod, mi_raw, sd_raw, md_raw;
  logic [CW:0]   dsum;
  logic          err, bypass, adv, in_acc, drain_step, ram_re, ram_we;
  logic          item_emit, item_sub, dr_emit, dr_sub, dr_done;
  logic [PW-1:0] s_addr, m_addr;

  // stage 1: sum
  s1_ctl_t s1_q, s1_d;
  logic signed [SW-1:0] acc_q, acc_d;
  logic [SAMPLE_WIDTH-1:0] old_rd;
  logic                    keep_rd;
  logic signed [SW-1:0] xe, olde, sum_now, sum_sel;
  logic signed [cbls_pkg::RECIP_W:0] scale;

  // stage 2: product
  logic                    s2_valid_q;
  logic signed [PRODW-1:0] prod_q;
  logic                    s2_keep_q, s2_done_q, s2_err_q;
  logic signed [PRODW-1:0] shifted, clamped;

  // stage 3: output register
  logic                              out_valid_q;
  logic signed [cbls_pkg::OUT_W-1:0] avg_q;
  logic                              keep_q, done_q, err_q;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign wpts_we     = cfg_we && (cfg_index_i == cbls_pkg::REG_WINDOW_POINTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpts_q  <= cbls_pkg::WPTS_RESET;
      recip_q <= cbls_pkg::RECIP_ONE;
    end else if (cfg_we) begin
      case (cfg_index_i)
        cbls_pkg::REG_WINDOW_POINTS:     wpts_q  <= cfg_data_i[cbls_pkg::WPTS_W-1:0];
        cbls_pkg::REG_WINDOW_RECIPROCAL: recip_q <= cfg_data_i[cbls_pkg::RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  assign err    = !wpts_q[0] || (int'(wpts_q) > int'(MAX_WINDOW));
  assign bypass = err || (wpts_q == cbls_pkg::WPTS_RESET);
  assign win    = CW'(wpts_q);
  assign half   = win >> 1;
  assign wine   = (PW + 1)'(win);
  assign hale   = (PW + 1)'(half);

  // ---------------- handshake ----------------
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = drain_q || !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign drain_step = drain_q && adv;
  assign ram_we     = in_acc && !bypass;
  assign ram_re     = ram_we || drain_step;

  // ---------------- address generation ----------------
  assign wpe  = {1'b0, wp_q};
  assign dwpe = {1'b0, dwp_q};
  assign dje  = (PW + 1)'(dj_q);

  // oldest sample of the window sits one past the write slot
  assign nxt_raw = wpe + 1'b1;
  assign nxt_mod = (nxt_raw >= wine) ? nxt_raw - wine : nxt_raw;
  // center position lags the newest sample by half a window
  assign mi_raw  = (wpe >= hale) ? wpe - hale : wpe + wine - hale;
  assign sd_raw  = dwpe + dje + 1'b1;
  assign md_raw  = dwpe + wine - hale + dje;

  always_comb begin
    if (drain_q) begin
      s_addr = PW'((sd_raw >= wine) ? sd_raw - wine : sd_raw);
      m_addr = PW'((md_raw >= wine) ? md_raw - wine : md_raw);
    end else begin
      s_addr = PW'(nxt_mod);
      m_addr = PW'(mi_raw);
    end
  end

  assign cnt_new   = (cnt_q < win) ? cnt_q + 1'b1 : cnt_q;
  assign item_emit = cnt_new > half;
  assign item_sub  = cnt_new >= win;
  assign dsum      = {1'b0, dcnt_q} + {1'b0, dj_q};
  assign dr_emit   = dsum > {1'b0, half};
  assign dr_sub    = dsum >= {1'b0, win};
  assign dr_done   = dj_q == half;

  // ---------------- issue sequencer ----------------
  always_comb begin
    wp_d    = wp_q;
    cnt_d   = cnt_q;
    drain_d = drain_q;
    dj_d    = dj_q;
    dwp_d   = dwp_q;
    dcnt_d  = dcnt_q;
    if (wpts_we) begin
      wp_d  = '0;
      cnt_d = '0;
    end else if (ram_we) begin
      if (last_of_line_i) begin
        drain_d = 1'b1;
        dj_d    = CW'(1);
        dwp_d   = wp_q;
        dcnt_d  = cnt_new;
        wp_d    = '0;
        cnt_d   = '0;
      end else begin
        wp_d  = PW'(nxt_mod);
        cnt_d = cnt_new;
      end
    end else if (drain_step) begin
      if (dr_done) begin
        drain_d = 1'b0;
      end else begin
        dj_d = dj_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      cnt_q   <= '0;
      drain_q <= 1'b0;
      dj_q    <= '0;
      dwp_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      wp_q    <= wp_d;
      cnt_q   <= cnt_d;
      drain_q <= drain_d;
      dj_q    <= dj_d;
      dwp_q   <= dwp_d;
      dcnt_q  <= dcnt_d;
    end
  end

  // ---------------- window memories ----------------
  cbls_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_WINDOW)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (sample_value_i),
    .re_i    (ram_re),
    .raddr_i (s_addr),
    .rdata_o (old_rd)
  );

  cbls_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WINDOW)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (keep_mask_i),
    .re_i    (ram_re),
    .raddr_i (m_addr),
    .rdata_o (keep_rd)
  );

  // ---------------- stage 1: running sum ----------------
  always_comb begin
    s1_d       = s1_q;
    s1_d.valid = in_acc || drain_step;
    if (drain_q) begin
      s1_d.bypass = 1'b0;
      s1_d.emit   = dr_emit;
      s1_d.sub    = dr_sub;
      s1_d.done   = dr_done;
      s1_d.clear  = dr_done;
      s1_d.keep   = 1'b0;
      s1_d.err    = 1'b0;
      s1_d.x      = '0;
    end else begin
      s1_d.bypass = bypass;
      s1_d.emit   = bypass || item_emit;
      s1_d.sub    = item_sub;
      s1_d.done   = bypass && last_of_line_i;
      s1_d.clear  = 1'b0;
      s1_d.keep   = keep_mask_i;
      s1_d.err    = err;
      s1_d.x      = sample_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (adv) begin
      s1_q <= s1_d;
    end
  end

  assign xe      = {{CW{s1_q.x[SAMPLE_WIDTH-1]}}, s1_q.x};
  assign olde    = {{CW{old_rd[SAMPLE_WIDTH-1]}}, old_rd};
  assign sum_now = acc_q + xe;
  assign sum_sel = s1_q.bypass ? xe : sum_now;
  assign scale   = s1_q.bypass ? $signed({1'b0, cbls_pkg::RECIP_ONE})
                               : $signed({1'b0, recip_q});

  always_comb begin
    acc_d = acc_q;
    if (wpts_we) begin
      acc_d = '0;
    end else if (adv && s1_q.valid && !s1_q.bypass) begin
      if (s1_q.clear) begin
        acc_d = '0;
      end else begin
        acc_d = s1_q.sub ? sum_now - olde : sum_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // ---------------- stage 2: scale ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_q.valid && s1_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q    <= sum_sel * scale;
      s2_keep_q <= s1_q.bypass ? s1_q.keep : keep_rd;
      s2_done_q <= s1_q.done;
      s2_err_q  <= s1_q.err;
    end
  end

  // ---------------- stage 3: saturate and present ----------------
  // arithmetic shift gives the floor of the quotient for negative products
  assign shifted = prod_q >>> cbls_pkg::FRAC_BITS;

  always_comb begin
    if (shifted > SAT_HI) begin
      clamped = SAT_HI;
    end else if (shifted < SAT_LO) begin
      clamped = SAT_LO;
    end else begin
      clamped = shifted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      avg_q  <= clamped[cbls_pkg::OUT_W-1:0];
      keep_q <= s2_keep_q;
      done_q <= s2_done_q;
      err_q  <= s2_err_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign average_value_o = avg_q;
  assign keep_out_o      = keep_q;
  assign line_done_o     = done_q;
  assign config_error_o  = err_q;

`ifndef SYNTH
  a_ptr_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bypass |-> (({1'b0, wp_q} < wine) && (cnt_q <= win)))
    else $error("write pointer or fill count outside the window");

  a_drain_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> ((dj_q != '0) && (dj_q <= half)))
    else $error("drain step outside 1..half window");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_q.valid && s1_q.clear) |-> (s1_q.done && s1_q.emit && !s1_q.bypass))
    else $error("line clear without a line_done result");
`endif

endmodule

[bench/cbls_checker.sv]
// Line smoother checker: watches all channels, predicts each average and compares it.
`timescale 1ns / 1ps
module cbls_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic signed [15:0]                 sample_value_i,
  input  logic                               keep_mask_i,
  input  logic                               last_of_line_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic signed [cbls_pkg::OUT_W-1:0]  average_value_i,
  input  logic                               keep_out_i,
  input  logic                               line_done_i,
  input  logic                               config_error_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [cbls_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cbls_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  localparam int unsigned WIN_DEPTH = 31;

  typedef struct {
    logic signed [cbls_pkg::OUT_W-1:0] avg;
    logic                              keep;
    logic                              done;
    logic                              err;
  } line_avg_t;

  line_avg_t                    avg_due[$];
  logic [cbls_pkg::WPTS_W-1:0]  win_len;
  logic [cbls_pkg::RECIP_W-1:0] recip;
  logic signed [15:0]           win_samp [WIN_DEPTH];
  logic                         win_keep [WIN_DEPTH];
  longint                       run_sum;
  int unsigned                  fill_cnt;
  int unsigned                  wr_ptr;
  int                           mismatches;

  function automatic logic signed [cbls_pkg::OUT_W-1:0] clamp16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // floor(sum * recip / 2^16): arithmetic shift rounds toward minus infinity
  function automatic logic signed [cbls_pkg::OUT_W-1:0] scale_sum(longint s);
    longint p;
    p = (s * longint'(recip)) >>> cbls_pkg::FRAC_BITS;
    return clamp16(p);
  endfunction

  task automatic push_avg(logic signed [cbls_pkg::OUT_W-1:0] a, logic k, logic d, logic e);
    line_avg_t r;
    r.avg  = a;
    r.keep = k;
    r.done = d;
    r.err  = e;
    avg_due.push_back(r);
  endtask

  task automatic clear_line();
    run_sum  = 0;
    fill_cnt = 0;
    wr_ptr   = 0;
  endtask

  task automatic advance_window(logic signed [15:0] x, logic k, logic last);
    int unsigned w, h, wp, cnt, s, j;
    logic        err;
    w   = win_len;
    err = !win_len[0];
    if (err || w == 1) begin
      push_avg(x, k, last, err);
      return;
    end
    h  = w / 2;
    wp = wr_ptr % w;
    win_samp[wp] = x;
    win_keep[wp] = k;
    run_sum += x;
    if (fill_cnt < w) fill_cnt++;
    cnt = fill_cnt;
    if (cnt >= h + 1) begin
      s = (wp + w - h) % w;
      push_avg(scale_sum(run_sum), win_keep[s], 1'b0, 1'b0);
    end
    if (cnt >= w) run_sum -= win_samp[(wp + 1) % w];
    if (last) begin
      // drain the trailing half window, sums clipped at the line end
      for (j = 1; j <= h; j++) begin
        if (cnt + j > h) begin
          s = (wp + w - h + j) % w;
          push_avg(scale_sum(run_sum), win_keep[s], logic'(j == h), 1'b0);
          if (cnt >= w - j) run_sum -= win_samp[(wp + 1 + j) % w];
        end
      end
      clear_line();
    end else begin
      wr_ptr = (wp + 1) % w;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    line_avg_t want;
    int        i;
    if (!rst_ni) begin
      for (i = 0; i < WIN_DEPTH; i++) begin
        win_samp[i] = '0;
        win_keep[i] = 1'b0;
      end
      avg_due.delete();
      clear_line();
      win_len      = cbls_pkg::WPTS_RESET;
      recip        = cbls_pkg::RECIP_ONE;
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == cbls_pkg::REG_WINDOW_POINTS) begin
          win_len = cfg_data_i[cbls_pkg::WPTS_W-1:0];
          clear_line();
        end else if (cfg_index_i == cbls_pkg::REG_WINDOW_RECIPROCAL) begin
          recip = cfg_data_i[cbls_pkg::RECIP_W-1:0];
        end
      end
      if (in_valid_i && !in_stall_i)
        advance_window(sample_value_i, keep_mask_i, last_of_line_i);
      if (out_valid_i && !out_stall_i) begin
        if (avg_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: avg=%0d keep=%0b done=%0b err=%0b",
                     average_value_i, keep_out_i, line_done_i, config_error_i);
        end else begin
          want = avg_due.pop_front();
          if (want.avg !== average_value_i || want.keep !== keep_out_i ||
              want.done !== line_done_i || want.err !== config_error_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch avg/keep/done/err: want %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
                       want.avg, want.keep, want.done, want.err,
                       average_value_i, keep_out_i, line_done_i, config_error_i);
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= avg_due.size();
    end
  end

endmodule

[bench/testbench.sv]
// Line smoother testbench top: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int IDLE_LIMIT    = 3000;
  localparam int RANDOM_ITEMS  = 170;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 80;
  localparam logic [cbls_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            in_valid       = 1'b0;
  logic [15:0]                     sample_value   = '0;
  logic                            keep_mask      = 1'b0;
  logic                            last_of_line   = 1'b0;
  logic                            out_stall      = 1'b0;
  logic                            cfg_valid      = 1'b0;
  logic [cbls_pkg::CFG_IDX_W-1:0]  cfg_index      = cbls_pkg::REG_WINDOW_POINTS;
  logic [cbls_pkg::CFG_DATA_W-1:0] cfg_data       = '0;

  logic                            in_stall;
  logic                            out_valid;
  logic [cbls_pkg::OUT_W-1:0]      average_value;
  logic                            keep_out;
  logic                            line_done;
  logic                            config_error;
  logic                            cfg_ready;

  int fail_cnt;
  int pending;
  int in_beats    = 0;
  int idle_cycles = 0;
  int holds_done  = 0;
  bit steady      = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  centered_boxcar_line_smoother u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .sample_value_i  (sample_value),
    .keep_mask_i     (keep_mask),
    .last_of_line_i  (last_of_line),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .average_value_o (average_value),
    .keep_out_o      (keep_out),
    .line_done_o     (line_done),
    .config_error_o  (config_error),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  cbls_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .sample_value_i  (sample_value),
    .keep_mask_i     (keep_mask),
    .last_of_line_i  (last_of_line),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .average_value_i (average_value),
    .keep_out_i      (keep_out),
    .line_done_i     (line_done),
    .config_error_i  (config_error),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_cnt),
    .pending_o       (pending)
  );

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [15:0] pick_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      default: return r[15:0];
    endcase
  endfunction

  function automatic int unsigned recip_for(int unsigned w);
    if (w == 0) return 0;
    return (65536 + w / 2) / w;
  endfunction

  // hold-off due: first one lands inside the long wide-window line
  function automatic bit hold_due();
    return (holds_done < 2) && (in_beats >= 40 + 110 * holds_done);
  endfunction

  task automatic send_sample(logic [15:0] x, logic k, logic l);
    int gap;
    in_valid     <= 1'b1;
    sample_value <= x;
    keep_mask    <= k;
    last_of_line <= l;
    do @(posedge clk_i); while (in_stall);
    in_beats++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_line(int len, bit closed);
    int i;
    for (i = 0; i < len; i++)
      send_sample(pick_sample(), 1'($urandom_range(0, 1)), closed && (i == len - 1));
  endtask

  task automatic write_reg(logic [cbls_pkg::CFG_IDX_W-1:0] idx,
                           logic [cbls_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // wait for every expected average, then give a drain time to finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_window(int unsigned w, int unsigned r);
    logic [cbls_pkg::CFG_DATA_W-1:0] d;
    settle();
    d = cbls_pkg::CFG_DATA_W'($urandom());
    d[cbls_pkg::WPTS_W-1:0] = w[cbls_pkg::WPTS_W-1:0];
    write_reg(cbls_pkg::REG_WINDOW_POINTS, d);
    write_reg(cbls_pkg::REG_WINDOW_RECIPROCAL, r[cbls_pkg::CFG_DATA_W-1:0]);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls, plus two long hold-offs so the block backs up
  initial begin
    int n;
    wait (rst_ni);
    forever begin
      if (hold_due()) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall <= 1'b0;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        while (n > 0 && !hold_due()) begin
          @(posedge clk_i);
          n--;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL centered_boxcar_line_smoother");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          directed_end, nlines, li, len;
    int unsigned w, r;
    bit          closed;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass-through after reset
    send_sample(16'h7fff, 1'b1, 1'b0);
    send_sample(16'h8000, 1'b0, 1'b1);
    send_sample(16'h0000, 1'b1, 1'b1);
    // even windows flag an error and pass samples through
    set_window(0, 32'(cbls_pkg::RECIP_ONE));
    send_sample(16'd1234, 1'b1, 1'b0);
    send_sample(16'hffff, 1'b0, 1'b1);
    set_window(4, 16384);
    send_sample(16'h8000, 1'b1, 1'b1);
    send_sample(16'h7fff, 1'b0, 1'b0);
    settle();
    write_reg(REG_UNMAPPED, cbls_pkg::CFG_DATA_W'($urandom()));
    cfg_valid <= 1'b0;
    // window of three: one-sample line, two-sample line, normal line
    set_window(3, recip_for(3));
    send_sample(16'd300, 1'b1, 1'b1);
    send_sample(16'h8000, 1'b1, 1'b0);
    send_sample(16'h8000, 1'b0, 1'b1);
    send_line(5, 1'b1);
    // widest window, short lines, saturating both ways
    set_window(31, 32'(cbls_pkg::RECIP_ONE));
    send_sample(16'h7fff, 1'b1, 1'b0);
    send_sample(16'h7fff, 1'b0, 1'b0);
    send_sample(16'h7fff, 1'b1, 1'b1);
    send_sample(16'h8000, 1'b1, 1'b0);
    send_sample(16'h8000, 1'b0, 1'b1);
    // zero reciprocal
    set_window(5, 0);
    send_line(3, 1'b1);
    directed_end = in_beats;

    // long line in the widest window while the receiver holds off
    set_window(31, recip_for(31));
    send_line(64, 1'b1);

    while (in_beats < directed_end + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = 2 * $urandom_range(0, 15);
        1:       w = 1;
        2:       w = 31;
        default: w = 2 * $urandom_range(1, 7) + 1;
      endcase
      case ($urandom_range(0, 9))
        0:       r = 0;
        1:       r = 32'(cbls_pkg::RECIP_ONE);
        2:       r = $urandom_range(0, 65536);
        default: r = recip_for(w);
      endcase
      set_window(w, r);
      nlines = $urandom_range(1, 4);
      for (li = 0; li < nlines; li++) begin
        steady = ($urandom_range(0, 3) == 0);
        if (w < 3 || !w[0])
          len = $urandom_range(1, 8);
        else if ($urandom_range(0, 7) == 0)
          len = $urandom_range(1, w / 2 + 1);
        else
          len = $urandom_range(1, 2 * w + 4);
        // now and then leave the last line open; the next window write restarts it
        closed = !(li == nlines - 1 && $urandom_range(0, 6) == 0);
        send_line(len, closed);
      end
      steady = 1'b0;
    end

    settle();
    if (fail_cnt == 0 && pending == 0)
      $display("PASS centered_boxcar_line_smoother");
    else
      $display("FAIL centered_boxcar_line_smoother");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/cbls_pkg.sv
rtl/core/cbls_ram.sv
rtl/core/centered_boxcar_line_smoother.sv
bench/cbls_checker.sv
bench/testbench.sv
